@@ design/m2cv_pkg.sv @@
package m2cv_pkg;

    // Event kinds carried in s_tuser.
    localparam logic [2:0] OP_NOTE_ON  = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF = 3'd1;
    localparam logic [2:0] OP_BEND     = 3'd2;
    localparam logic [2:0] OP_VELOCITY = 3'd3;
    localparam logic [2:0] OP_CC       = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LOWEST_NOTE     = 3'd0;
    localparam logic [2:0] CFG_PITCH_OFFSET_Q8 = 3'd1;
    localparam logic [2:0] CFG_PITCH_STEP_Q8   = 3'd2;
    localparam logic [2:0] CFG_PITCH_SLOT      = 3'd3;
    localparam logic [2:0] CFG_VELOCITY_ENABLE = 3'd4;
    localparam logic [2:0] CFG_VELOCITY_SLOT   = 3'd5;

    localparam logic [17:0] RESET_STEP_Q8       = 18'd17472;
    localparam logic [2:0]  RESET_VELOCITY_SLOT = 3'd1;

    localparam logic [13:0] BEND_CENTER = 14'd8192;
    localparam logic [7:0]  GATE_SPAN   = 8'd60;

    typedef logic signed [12:0] bend_t;

    localparam bend_t BEND_MAX = 13'sd4095;
    localparam bend_t BEND_MIN = -13'sd4096;

endpackage

@@ design/m2cv_bend.sv @@
module m2cv_bend
    import m2cv_pkg::*;
(
    input  logic [13:0] value,
    input  logic [5:0]  bend_up,
    input  logic [5:0]  bend_down,
    output bend_t       bend
);

    logic        is_up;
    logic        is_center;
    logic [13:0] mag;
    logic [5:0]  range_sel;
    logic [14:0] range_k;
    logic [27:0] prod;
    logic [27:0] up_sum;
    logic [25:0] up_quarter;
    logic [26:0] up_fold;
    logic [13:0] q_up;
    logic [27:0] dn_sum;
    logic [12:0] q_dn;

    assign is_up     = value > BEND_CENTER;
    assign is_center = value == BEND_CENTER;
    assign mag       = is_up ? (value - BEND_CENTER) : (BEND_CENTER - value);
    assign range_sel = is_up ? bend_up : bend_down;

    // Semitones times 68.25 times 4, built as 256 + 16 + 1.
    assign range_k = {1'b0, range_sel, 8'd0} + {5'd0, range_sel, 4'd0} + {9'd0, range_sel};
    assign prod    = 28'(mag) * 28'(range_k);

    // Above center the span is 8191 * 4: round, drop the factor of four, then
    // divide by 2^13 - 1 with the fold-back trick (exact while the quotient stays
    // below 8192).
    assign up_sum     = prod + 28'd16382;
    assign up_quarter = up_sum[27:2];
    assign up_fold    = 27'(up_quarter) + 27'(up_quarter[25:13]) + 27'd1;
    assign q_up       = up_fold[26:13];

    // Below center the span is a power of two.
    assign dn_sum = prod + 28'd16384;
    assign q_dn   = dn_sum[27:15];

    always_comb
    begin
        if (is_center)
        begin
            bend = '0;
        end
        else if (is_up)
        begin
            bend = (q_up > 14'd4095) ? BEND_MAX : $signed(13'(q_up));
        end
        else
        begin
            bend = (q_dn > 13'd4096) ? BEND_MIN : -$signed(q_dn);
        end
    end

endmodule

@@ design/midi_to_cv_converter.sv @@
// MIDI to control-voltage converter. Each word on the slave stream is one MIDI
// event (note on, note off, pitch bend, velocity or controller change, selected
// by s_tuser) and yields exactly one word on the master stream: an optional DAC
// code with its channel, plus the gate level after the event. Pitch codes follow
// the programmed offset and per-semitone step (both in DAC codes times 256), plus
// the stored bend, rounded and clamped to the DAC range; velocity and controller
// amounts scale 0..127 onto the full range. The block takes one event per clock
// while the master stream accepts words; each event passes an input register, a
// product register (pitch and bend multipliers) and the output register before
// its result word is on the master stream; a stalled master stream holds the
// pipeline but bubbles are squeezed out. The configuration port must only be
// written while no event is in flight.
module midi_to_cv_converter
    import m2cv_pkg::*;
#(
    parameter int DAC_BITS = 12
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [2:0]                             cfg_addr,
    input  logic [20:0]                            cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // note[6:0], value[20:7], bend_up[26:21], bend_down[32:27], zero fill
    input  logic [39:0]                            s_tdata,
    // op[2:0]
    input  logic [2:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // dac_slot[2:0], dac_code[DAC_BITS+2:3], gate_level[DAC_BITS+3], zero fill
    output logic [((DAC_BITS + 4 + 7) / 8) * 8 - 1:0] m_tdata,
    // dac_write
    output logic                                   m_tuser
);

    localparam int OUT_W   = ((DAC_BITS + 4 + 7) / 8) * 8;
    localparam int DAC_MAX = (1 << DAC_BITS) - 1;
    localparam int AMT_A   = DAC_MAX / 127;
    localparam int AMT_R   = DAC_MAX % 127;

    typedef struct packed {
        logic                 wr;
        logic                 use_pitch;
        logic [2:0]           slot;
        logic signed [26:0]   total;
        bend_t                bend;
        logic [DAC_BITS-1:0]  amount;
        logic                 gate;
    } mid_t;

    // Configuration registers.
    logic [6:0]         lowest_note_reg;
    logic signed [20:0] pitch_offset_q8_reg;
    logic [17:0]        pitch_step_q8_reg;
    logic [2:0]         pitch_slot_reg;
    logic               velocity_enable_reg;
    logic [2:0]         velocity_slot_reg;

    // Event state.
    logic [6:0] current_note_reg;
    bend_t      bend_offset_reg;
    logic       gate_state_reg;

    // Pipeline.
    logic       in_valid_reg;
    logic [2:0] op_reg;
    logic [6:0] note_reg;
    logic [13:0] value_reg;
    logic [5:0] up_reg;
    logic [5:0] down_reg;

    logic       mid_valid_reg;
    mid_t       mid_reg;
    mid_t       mid_next;

    logic                out_valid_reg;
    logic                out_wr_reg;
    logic [2:0]          out_slot_reg;
    logic [DAC_BITS-1:0] out_code_reg;
    logic                out_gate_reg;

    logic out_ready;
    logic mid_ready;
    logic in_ready;
    logic adv_in;
    logic adv_mid;

    assign out_ready = !out_valid_reg || m_tready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || mid_ready;
    assign s_tready  = in_ready;
    assign adv_in    = in_valid_reg && mid_ready;
    assign adv_mid   = mid_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_note_reg     <= '0;
            pitch_offset_q8_reg <= '0;
            pitch_step_q8_reg   <= RESET_STEP_Q8;
            pitch_slot_reg      <= '0;
            velocity_enable_reg <= 1'b0;
            velocity_slot_reg   <= RESET_VELOCITY_SLOT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_LOWEST_NOTE:     lowest_note_reg     <= cfg_data[6:0];
                CFG_PITCH_OFFSET_Q8: pitch_offset_q8_reg <= $signed(cfg_data);
                CFG_PITCH_STEP_Q8:   pitch_step_q8_reg   <= cfg_data[17:0];
                CFG_PITCH_SLOT:      pitch_slot_reg      <= cfg_data[2:0];
                CFG_VELOCITY_ENABLE: velocity_enable_reg <= cfg_data[0];
                CFG_VELOCITY_SLOT:   velocity_slot_reg   <= cfg_data[2:0];
                default:             ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_tvalid)
        begin
            op_reg    <= s_tuser;
            note_reg  <= s_tdata[6:0];
            value_reg <= s_tdata[20:7];
            up_reg    <= s_tdata[26:21];
            down_reg  <= s_tdata[32:27];
        end
    end

    // Product stage: event decode, state update, multipliers.
    bend_t              bend_calc;
    bend_t              bend_eff;
    logic               below;
    logic               in_span;
    logic [6:0]         note_eff;
    logic signed [7:0]  note_diff;
    logic signed [25:0] note_prod;
    logic [6:0]               amt_v;
    logic                     amt_big;
    logic [DAC_BITS+6:0]      amt_hi;
    logic [13:0]              amt_y;
    logic [14:0]              amt_fold;
    logic [DAC_BITS-1:0]      amt_code;

    m2cv_bend u_bend
    (
        .value     (value_reg),
        .bend_up   (up_reg),
        .bend_down (down_reg),
        .bend      (bend_calc)
    );

    assign below     = note_reg < lowest_note_reg;
    assign in_span   = {1'b0, note_reg} <= ({1'b0, lowest_note_reg} + GATE_SPAN);
    assign note_eff  = (op_reg == OP_NOTE_ON) ? note_reg : current_note_reg;
    assign note_diff = $signed({1'b0, note_eff}) - $signed({1'b0, lowest_note_reg});
    assign note_prod = 26'(note_diff) * 26'($signed({1'b0, pitch_step_q8_reg}));
    assign bend_eff  = (op_reg == OP_BEND) ? bend_calc : bend_offset_reg;

    // v * (2^N - 1) / 127 split as v * a + v * r / 127 with r < 127; the small
    // quotient uses the 2^7 - 1 fold-back, exact for every v up to 127.
    assign amt_v    = value_reg[6:0];
    assign amt_big  = value_reg[13:7] != 7'd0;
    assign amt_hi   = (DAC_BITS + 7)'(amt_v) * (DAC_BITS + 7)'(AMT_A);
    assign amt_y    = 14'(amt_v) * 14'(AMT_R);
    assign amt_fold = 15'(amt_y) + 15'(amt_y[13:7]) + 15'd1;
    assign amt_code = amt_big ? '1 : (DAC_BITS'(amt_hi) + DAC_BITS'(amt_fold[14:7]));

    always_comb
    begin
        mid_next           = '0;
        mid_next.total     = 27'(note_prod) + 27'(pitch_offset_q8_reg);
        mid_next.bend      = bend_eff;
        mid_next.amount    = amt_code;
        mid_next.gate      = gate_state_reg;
        mid_next.use_pitch = 1'b1;
        mid_next.slot      = pitch_slot_reg;
        case (op_reg)
            OP_NOTE_ON:
            begin
                mid_next.wr = !below;
                if (below)
                begin
                    mid_next.gate = 1'b0;
                end
                else if (in_span)
                begin
                    mid_next.gate = 1'b1;
                end
            end
            OP_NOTE_OFF:
            begin
                mid_next.gate = 1'b0;
            end
            OP_BEND:
            begin
                mid_next.wr = 1'b1;
            end
            OP_VELOCITY:
            begin
                mid_next.wr        = velocity_enable_reg;
                mid_next.use_pitch = 1'b0;
                mid_next.slot      = velocity_slot_reg;
            end
            OP_CC:
            begin
                mid_next.wr        = 1'b1;
                mid_next.use_pitch = 1'b0;
            end
            default:
            begin
                mid_next.wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_note_reg <= '0;
            bend_offset_reg  <= '0;
            gate_state_reg   <= 1'b0;
            mid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (adv_in)
            begin
                if (op_reg == OP_NOTE_ON)
                begin
                    current_note_reg <= note_reg;
                end
                if (op_reg == OP_BEND)
                begin
                    bend_offset_reg <= bend_calc;
                end
                gate_state_reg <= mid_next.gate;
            end
            if (mid_ready)
            begin
                mid_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in)
        begin
            mid_reg <= mid_next;
        end
    end

    // Output stage: round the pitch sum, add bend, clamp, or pass the scaled amount.
    logic [26:0]         tot_mag;
    logic [26:0]         rnd_sum;
    logic [18:0]         rnd;
    logic signed [20:0]  rounded;
    logic signed [21:0]  code_s;
    logic [DAC_BITS-1:0] pitch_code;
    logic [DAC_BITS-1:0] code_sel;

    assign tot_mag = mid_reg.total[26] ? 27'(-mid_reg.total) : 27'(mid_reg.total);
    assign rnd_sum = tot_mag + 27'd128;
    assign rnd     = rnd_sum[26:8];
    assign rounded = mid_reg.total[26] ? -$signed(21'(rnd)) : $signed(21'(rnd));
    assign code_s  = 22'(rounded) + 22'(mid_reg.bend);

    always_comb
    begin
        if (code_s < 22'sd0)
        begin
            pitch_code = '0;
        end
        else if (code_s > $signed(22'(DAC_MAX)))
        begin
            pitch_code = '1;
        end
        else
        begin
            pitch_code = code_s[DAC_BITS-1:0];
        end
    end

    assign code_sel = mid_reg.use_pitch ? pitch_code : mid_reg.amount;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_mid)
        begin
            out_wr_reg   <= mid_reg.wr;
            out_slot_reg <= mid_reg.wr ? mid_reg.slot : 3'd0;
            out_code_reg <= mid_reg.wr ? code_sel : '0;
            out_gate_reg <= mid_reg.gate;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_wr_reg;
    assign m_tdata  = OUT_W'({out_gate_reg, out_code_reg, out_slot_reg});

    // A word without a DAC write carries no channel and no code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_wr_reg) |-> (out_slot_reg == 3'd0 && out_code_reg == '0))
        else $error("idle result word carries a code");

    // Note off always leaves the gate low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv_in && op_reg == OP_NOTE_OFF) |=> !gate_state_reg)
        else $error("gate still high after note off");

    // The slave side only stalls while the input register holds a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && mid_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    // A bend event stores exactly the bend its result word is built with.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv_in && op_reg == OP_BEND) |=> (bend_offset_reg == mid_reg.bend))
        else $error("stored bend differs from forwarded bend");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import m2cv_pkg::*;

    localparam int DAC_BITS = 12;
    localparam int OUT_W = ((DAC_BITS + 4 + 7) / 8) * 8;
    localparam longint DAC_MAX = (longint'(1) << DAC_BITS) - 1;
    localparam longint AMOUNT_MAX = 127;
    localparam longint BEND_NUM = 273;
    localparam longint BEND_DEN_UP = 8191 * 4;
    localparam longint BEND_DEN_DOWN = 8192 * 4;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_EVENTS = 55;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam logic [2:0] NO_REG = 3'd0;
    localparam logic [20:0] NO_DATA = 21'd0;
    localparam logic [20:0] OFFSET_MIN = 21'h100000;
    localparam logic [20:0] OFFSET_MAX = 21'h0FFFFF;
    localparam logic [20:0] STEP_MAX = 21'h03FFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [6:0]  note;
        logic [13:0] value;
        logic [5:0]  bend_up;
        logic [5:0]  bend_down;
    } midi_event_t;

    typedef struct packed {
        logic                write;
        logic [2:0]          slot;
        logic [DAC_BITS-1:0] code;
        logic                gate;
    } dac_result_t;

    typedef enum logic [0:0] {ROW_EVENT, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_addr;
        logic [20:0] reg_data;
        midi_event_t ev;
        logic        typed;
        dac_result_t res;
    } stim_row_t;

    localparam midi_event_t NO_EVENT = '0;
    localparam dac_result_t NO_RESULT = '0;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_addr;
    logic [20:0]        cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [39:0]        s_tdata;
    logic [2:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tuser;

    // Mirror of the configuration registers.
    logic [6:0]         reg_lowest = 7'd0;
    logic signed [20:0] reg_offset = 21'sd0;
    logic [17:0]        reg_step = RESET_STEP_Q8;
    logic [2:0]         reg_pitch_slot = 3'd0;
    logic               reg_vel_en = 1'b0;
    logic [2:0]         reg_vel_slot = RESET_VELOCITY_SLOT;

    // Converter state as the predictor sees it.
    logic [6:0]         cv_note = 7'd0;
    bend_t              cv_bend = '0;
    logic               cv_gate = 1'b0;

    dac_result_t        pending_dac[$];
    int                 mismatches = 0;
    int                 src_idle_pct = 0;
    int                 dst_idle_pct = 0;
    bit                 hold_req = 1'b0;

    stim_row_t directed_rows [36] = '{
        // Reset setup: span edges, clamping, bend saturation and centering.
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_NOTE_ON, 7'd0, 14'd0, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd0, 12'd0, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_NOTE_ON, 7'd60, 14'd0, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd0, 12'd4095, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_NOTE_ON, 7'd61, 14'd0, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd0, 12'd4095, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_NOTE_OFF, 7'd127, 14'd16383, 6'd63, 6'd63},
            1'b1, '{1'b0, 3'd0, 12'd0, 1'b0}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_NOTE_ON, 7'd127, 14'd0, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd0, 12'd4095, 1'b0}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_BEND, 7'd0, 14'd16383, 6'd63, 6'd0},
            1'b1, '{1'b1, 3'd0, 12'd4095, 1'b0}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_BEND, 7'd0, 14'd0, 6'd0, 6'd63},
            1'b1, '{1'b1, 3'd0, 12'd4095, 1'b0}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_NOTE_ON, 7'd0, 14'd0, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd0, 12'd0, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_BEND, 7'd0, 14'd8192, 6'd60, 6'd60},
            1'b1, '{1'b1, 3'd0, 12'd0, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_BEND, 7'd0, 14'd16383, 6'd1, 6'd0},
            1'b0, NO_RESULT},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_BEND, 7'd0, 14'd8193, 6'd60, 6'd0},
            1'b0, NO_RESULT},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_BEND, 7'd0, 14'd8191, 6'd0, 6'd60},
            1'b0, NO_RESULT},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_CC, 7'd0, 14'd127, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd0, 12'd4095, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_CC, 7'd0, 14'd0, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd0, 12'd0, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_CC, 7'd0, 14'd16383, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd0, 12'd4095, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_VELOCITY, 7'd0, 14'd100, 6'd0, 6'd0},
            1'b1, '{1'b0, 3'd0, 12'd0, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_UNUSED_LO, 7'd5, 14'd5, 6'd5, 6'd5},
            1'b1, '{1'b0, 3'd0, 12'd0, 1'b1}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_UNUSED_HI, 7'd127, 14'd16383, 6'd63, 6'd63},
            1'b1, '{1'b0, 3'd0, 12'd0, 1'b1}},
        // Raised lowest note, velocity channel on, negative offset extreme.
        '{ROW_WRITE, CFG_LOWEST_NOTE, 21'd64, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_VELOCITY_ENABLE, 21'd1, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_VELOCITY_SLOT, 21'd7, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_PITCH_SLOT, 21'd7, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_PITCH_OFFSET_Q8, OFFSET_MIN, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_PITCH_STEP_Q8, STEP_MAX, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_NOTE_ON, 7'd10, 14'd0, 6'd0, 6'd0},
            1'b1, '{1'b0, 3'd0, 12'd0, 1'b0}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_BEND, 7'd0, 14'd0, 6'd0, 6'd60},
            1'b0, NO_RESULT},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_VELOCITY, 7'd0, 14'd127, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd7, 12'd4095, 1'b0}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_VELOCITY, 7'd0, 14'd0, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd7, 12'd0, 1'b0}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_VELOCITY, 7'd0, 14'd16383, 6'd0, 6'd0},
            1'b1, '{1'b1, 3'd7, 12'd4095, 1'b0}},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_NOTE_ON, 7'd64, 14'd0, 6'd0, 6'd0},
            1'b0, NO_RESULT},
        // Top of the offset and lowest-note ranges, zero step, velocity channel off.
        '{ROW_WRITE, CFG_PITCH_OFFSET_Q8, OFFSET_MAX, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_LOWEST_NOTE, 21'd127, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_PITCH_STEP_Q8, NO_DATA, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_WRITE, CFG_VELOCITY_ENABLE, NO_DATA, NO_EVENT, 1'b0, NO_RESULT},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_NOTE_ON, 7'd127, 14'd0, 6'd0, 6'd0},
            1'b0, NO_RESULT},
        '{ROW_EVENT, NO_REG, NO_DATA, '{OP_CC, 7'd0, 14'd64, 6'd0, 6'd0},
            1'b0, NO_RESULT}
    };

    midi_to_cv_converter #(.DAC_BITS(DAC_BITS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic longint round_div(longint num, longint den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((2 * (-num) + den) / (2 * den));
    endfunction

    function automatic logic [DAC_BITS-1:0] clamp_code(longint v);
        if (v < 0)
            return '0;
        if (v > DAC_MAX)
            return DAC_BITS'(DAC_MAX);
        return DAC_BITS'(v);
    endfunction

    function automatic logic [DAC_BITS-1:0] pitch_code();
        longint n;
        longint lo;
        longint off;
        longint st;
        longint bend;
        n = cv_note;
        lo = reg_lowest;
        off = reg_offset;
        st = reg_step;
        bend = cv_bend;
        return clamp_code(round_div(off + (n - lo) * st, 256) + bend);
    endfunction

    function automatic logic [DAC_BITS-1:0] scaled_amount(logic [13:0] amount);
        longint v;
        v = amount;
        return clamp_code((v * DAC_MAX) / AMOUNT_MAX);
    endfunction

    function automatic dac_result_t predict_dac(midi_event_t ev);
        dac_result_t r;
        longint d;
        longint b;
        longint u;
        longint w;
        longint center;
        longint bmax;
        longint bmin;
        r = '0;
        case (ev.op)
            OP_NOTE_ON:
            begin
                cv_note = ev.note;
                if (ev.note >= reg_lowest)
                begin
                    r.write = 1'b1;
                    r.slot = reg_pitch_slot;
                    r.code = pitch_code();
                    if (int'(ev.note) <= int'(reg_lowest) + int'(GATE_SPAN))
                        cv_gate = 1'b1;
                end
                else
                    cv_gate = 1'b0;
            end
            OP_NOTE_OFF:
                cv_gate = 1'b0;
            OP_BEND:
            begin
                center = BEND_CENTER;
                bmax = BEND_MAX;
                bmin = BEND_MIN;
                d = ev.value;
                d = d - center;
                u = ev.bend_up;
                w = ev.bend_down;
                if (d > 0)
                    b = round_div(d * u * BEND_NUM, BEND_DEN_UP);
                else if (d < 0)
                    b = round_div(d * w * BEND_NUM, BEND_DEN_DOWN);
                else
                    b = 0;
                if (b > bmax)
                    b = bmax;
                if (b < bmin)
                    b = bmin;
                cv_bend = bend_t'(b);
                r.write = 1'b1;
                r.slot = reg_pitch_slot;
                r.code = pitch_code();
            end
            OP_VELOCITY:
            begin
                if (reg_vel_en)
                begin
                    r.write = 1'b1;
                    r.slot = reg_vel_slot;
                    r.code = scaled_amount(ev.value);
                end
            end
            OP_CC:
            begin
                r.write = 1'b1;
                r.slot = reg_pitch_slot;
                r.code = scaled_amount(ev.value);
            end
            default:
            begin
            end
        endcase
        r.gate = cv_gate;
        return r;
    endfunction

    function automatic midi_event_t random_event();
        midi_event_t ev;
        int pick;
        int n;
        ev.note = 7'($urandom_range(127));
        ev.value = 14'($urandom_range(16383));
        ev.bend_up = 6'($urandom_range(60));
        ev.bend_down = 6'($urandom_range(60));
        if ($urandom_range(7) == 0)
        begin
            ev.bend_up = 6'($urandom_range(63));
            ev.bend_down = 6'($urandom_range(63));
        end
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            // Most notes land in or just above the gate span of the setup.
            ev.op = OP_NOTE_ON;
            n = int'(reg_lowest) + int'($urandom_range(64));
            if (n <= 127 && $urandom_range(4) != 0)
                ev.note = 7'(n);
        end
        else if (pick < 40)
            ev.op = OP_NOTE_OFF;
        else if (pick < 60)
        begin
            ev.op = OP_BEND;
            case ($urandom_range(7))
                0: ev.value = 14'd0;
                1: ev.value = BEND_CENTER;
                2: ev.value = 14'd16383;
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (pick < 75)
                ev.op = OP_VELOCITY;
            else if (pick < 92)
                ev.op = OP_CC;
            else
                ev.op = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            if ($urandom_range(5) != 0)
                ev.value = 14'($urandom_range(127));
        end
        return ev;
    endfunction

    task automatic send_event(midi_event_t ev, logic typed, dac_result_t typed_res);
        dac_result_t r;
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = {7'd0, ev.bend_down, ev.bend_up, ev.value, ev.note};
        s_tuser = ev.op;
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_dac(ev);
        pending_dac.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_dac.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [20:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_data = data;
        case (addr)
            CFG_LOWEST_NOTE:     reg_lowest = data[6:0];
            CFG_PITCH_OFFSET_Q8: reg_offset = data;
            CFG_PITCH_STEP_Q8:   reg_step = data[17:0];
            CFG_PITCH_SLOT:      reg_pitch_slot = data[2:0];
            CFG_VELOCITY_ENABLE: reg_vel_en = data[0];
            CFG_VELOCITY_SLOT:   reg_vel_slot = data[2:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Flavor 0 writes the bottom of every range, 1 the top, anything else a
    // random setup biased toward musically useful pitch settings.
    task automatic program_setup(int flavor);
        logic [20:0] lo;
        logic [20:0] off;
        logic [20:0] st;
        logic [20:0] ps;
        logic [20:0] ve;
        logic [20:0] vs;
        if (flavor == 0)
        begin
            lo = '0;
            off = OFFSET_MIN;
            st = '0;
            ps = '0;
            ve = '0;
            vs = '0;
        end
        else if (flavor == 1)
        begin
            lo = 21'd127;
            off = OFFSET_MAX;
            st = STEP_MAX;
            ps = 21'd7;
            ve = 21'd1;
            vs = 21'd7;
        end
        else
        begin
            lo = ($urandom_range(3) == 0) ? 21'($urandom_range(127))
                                          : 21'($urandom_range(60, 12));
            off = ($urandom_range(3) == 0) ? 21'($urandom)
                                           : 21'(int'($urandom_range(32768)) - 16384);
            st = ($urandom_range(3) == 0) ? 21'($urandom_range(262143))
                                          : 21'($urandom_range(20000, 16000));
            ps = 21'($urandom_range(7));
            ve = 21'($urandom_range(1));
            vs = 21'($urandom_range(7));
        end
        write_reg(CFG_LOWEST_NOTE, lo);
        write_reg(CFG_PITCH_OFFSET_Q8, off);
        write_reg(CFG_PITCH_STEP_Q8, st);
        write_reg(CFG_PITCH_SLOT, ps);
        write_reg(CFG_VELOCITY_ENABLE, ve);
        write_reg(CFG_VELOCITY_SLOT, vs);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // Long back-pressure so the pipeline fills and stalls its input.
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready = ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        dac_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_dac.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word, expected none, got write %0d code %0d",
                         $time, m_tuser, m_tdata[DAC_BITS+2:3]);
            end
            else
            begin
                want = pending_dac.pop_front();
                check_field("dac_write", 16'(want.write), 16'(m_tuser));
                check_field("dac_slot", 16'(want.slot), 16'(m_tdata[2:0]));
                check_field("dac_code", 16'(want.code), 16'(m_tdata[DAC_BITS+2:3]));
                check_field("gate_level", 16'(want.gate), 16'(m_tdata[DAC_BITS+3]));
            end
        end
    end

    initial
    begin
        int flavor;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 17;
        dst_idle_pct = 70;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(directed_rows[i].reg_addr, directed_rows[i].reg_data);
            end
            else
                send_event(directed_rows[i].ev, directed_rows[i].typed,
                           directed_rows[i].res);
        end

        for (int mode = 0; mode < 3; mode++)
        begin
            src_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 70 : 0;
            dst_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 17 : 0;
            for (int ph = 0; ph < 3; ph++)
            begin
                flavor = (ph == 0 && mode < 2) ? mode : 2;
                wait_drained();
                program_setup(flavor);
                if (ph == 0)
                    hold_req = 1'b1;
                repeat (PHASE_EVENTS)
                    send_event(random_event(), 1'b0, NO_RESULT);
            end
        end

        wait_drained();
        repeat (10)
            @(posedge clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
